>>> design/ardl_pkg.sv
// Shared constants and types for the adaptive reply drop limiter.
package ardl_pkg;

  localparam longint unsigned FULL_SCALE_DEF = 64'd32767;
  localparam int unsigned PERCENT_DIV = 100;

  localparam int unsigned SENT_W      = 17;
  localparam int unsigned TARGET_W    = 16;
  localparam int unsigned RND_W       = 15;
  localparam int unsigned LEVEL_OUT_W = 16;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd100;
  localparam logic [SENT_W-1:0]   SENT_MAX     = '1;

  // Bits of s_tuser.
  localparam int unsigned TUSER_ACTION = 0;
  localparam int unsigned TUSER_REPLY  = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } ardl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ardl_div_status_t;

endpackage

>>> design/ardl_div.sv
// Restoring divider that produces one quotient bit per cycle.
module ardl_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [NUM_W-1:0]            num,
  input  logic [DEN_W-1:0]            den,
  output logic [NUM_W-1:0]            quotient,
  output ardl_pkg::ardl_div_status_t  status
);
  import ardl_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;

  logic [DEN_W:0] rem_shift;
  logic [DEN_W:0] diff;

  assign rem_shift = {rem, quo[NUM_W-1]};
  assign diff      = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num;
      rem     <= '0;
      divisor <= den;
    end else if (busy && cnt != '0) begin
      if (!diff[DEN_W]) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = busy && (cnt == '0);

endmodule

>>> design/adaptive_reply_drop_limiter.sv
// Top level of the adaptive reply drop limiter: sequencer, state and stream ports.
//
// Each input beat on the s_ group is either an outgoing-message event or a
// one-second tick (s_tuser bit 0). Own requests always pass and leave the state
// alone. A reply is dropped when the drop level is positive and above the
// supplied random value. A reply that passes while the count for this second
// is already above target_per_second recomputes the drop level as
// excess * FULL_SCALE / target, clamped to FULL_SCALE+1 (always drop). A tick
// in a second without overage lowers the level by FULL_SCALE/100.
// Every input beat yields exactly one output beat on the m_ group.
// An ordinary beat goes through the EMIT state on its way to the output
// register, and s_tready is back once the sequencer returns to idle. A reply
// that recomputes the level goes through the MUL, LOAD, DIV and EMIT states,
// with the restoring divider producing one quotient bit a cycle; no new beat
// goes in until the sequencer is idle again.
// s_tready is high only while the sequencer is idle; the block takes a new beat
// while the previous result still waits in the output register, and holds a
// finished result until that register is free when the receiver stalls.
// Reset clears the counter and drop level and sets the target to 100.
// The target register may only be written while no beat is in flight.
module adaptive_reply_drop_limiter #(
  parameter longint unsigned FULL_SCALE = ardl_pkg::FULL_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration: target replies per second.
  input  logic                           cfg_we,
  input  logic [ardl_pkg::TARGET_W-1:0]  cfg_data,
  // Input beats.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,  // [14:0] random_value, [15] zero
  input  logic [1:0]                     s_tuser,  // [0] action, [1] is_reply
  // Result beats.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata   // [0] send_allowed,
                                                   // [16:1] drop_level_now, [23:17] zero
);
  import ardl_pkg::*;

  localparam int unsigned FS_W    = $clog2(FULL_SCALE + 1);
  localparam int unsigned LEVEL_W = $clog2(FULL_SCALE + 2);
  localparam int unsigned PROD_W  = SENT_W + FS_W;
  localparam int unsigned CMP_W   = LEVEL_W + RND_W;

  localparam logic [LEVEL_W-1:0] CAP_L  = LEVEL_W'(FULL_SCALE + 1);
  localparam logic [LEVEL_W-1:0] STEP_L = LEVEL_W'(FULL_SCALE / PERCENT_DIV);
  localparam logic [FS_W-1:0]    FS_L   = FS_W'(FULL_SCALE);
  localparam logic [PROD_W-1:0]  CAP_P  = PROD_W'(FULL_SCALE + 1);

  // The reported level is the low bits of the internal one.
  function automatic logic [LEVEL_OUT_W-1:0] trim_level(logic [LEVEL_W-1:0] v);
    logic [LEVEL_W+LEVEL_OUT_W-1:0] w;
    w = (LEVEL_W + LEVEL_OUT_W)'(v);
    return w[LEVEL_OUT_W-1:0];
  endfunction

  ardl_state_t state, state_next;

  logic [TARGET_W-1:0]    target;
  logic [SENT_W-1:0]      sent;
  logic [LEVEL_W-1:0]     drop_level;
  logic [SENT_W-1:0]      excess;
  logic [PROD_W-1:0]      prod;
  logic                   res_allowed;
  logic [LEVEL_OUT_W-1:0] res_level;

  logic                   accept;
  logic                   div_start;
  logic                   out_load;
  logic                   is_tick;
  logic                   is_reply;
  logic [RND_W-1:0]       rnd;
  logic                   over;
  logic                   drop_hit;
  logic [LEVEL_W-1:0]     tick_level;
  logic [PROD_W-1:0]      quotient;
  logic [LEVEL_W-1:0]     q_level;
  ardl_div_status_t       div_status;

  assign accept   = s_tvalid && s_tready;
  assign is_tick  = s_tuser[TUSER_ACTION];
  assign is_reply = s_tuser[TUSER_REPLY];
  assign rnd      = s_tdata[RND_W-1:0];
  assign over     = sent > {1'b0, target};
  assign drop_hit = (drop_level != '0) && (CMP_W'(drop_level) > CMP_W'(rnd));

  // Quiet-second tick: lower the level by one percent of full scale, floored at 0.
  always_comb begin
    tick_level = drop_level;
    if (!over && drop_level != '0) begin
      tick_level = (drop_level > STEP_L) ? drop_level - STEP_L : '0;
    end
  end

  // Clamp the quotient to the always-drop level.
  assign q_level = (quotient > CAP_P) ? CAP_L : quotient[LEVEL_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!is_tick && is_reply && !drop_hit && over && target != '0) begin
            state_next = ST_MUL;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_MUL:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (div_status.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: s_tready  = 1'b1;
      ST_LOAD: div_start = 1'b1;
      ST_EMIT: out_load  = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TARGET_RESET;
    end else if (cfg_we) begin
      target <= cfg_data;
    end
  end

  // Counter and drop level.
  always_ff @(posedge clk) begin
    if (rst) begin
      sent       <= '0;
      drop_level <= '0;
    end else if (accept) begin
      if (is_tick) begin
        drop_level <= tick_level;
        sent       <= '0;
      end else if (is_reply && !drop_hit) begin
        if (over && target == '0) begin
          drop_level <= CAP_L;
        end
        if (sent != SENT_MAX) begin
          sent <= sent + 1'b1;
        end
      end
    end else if (state == ST_DIV && div_status.done) begin
      drop_level <= q_level;
    end
  end

  // Pending result and operands for the overage path.
  always_ff @(posedge clk) begin
    if (accept) begin
      excess <= sent - {1'b0, target};
      if (is_tick) begin
        res_allowed <= 1'b0;
        res_level   <= trim_level(tick_level);
      end else if (!is_reply) begin
        res_allowed <= 1'b1;
        res_level   <= trim_level(drop_level);
      end else if (drop_hit) begin
        res_allowed <= 1'b0;
        res_level   <= trim_level(drop_level);
      end else begin
        res_allowed <= 1'b1;
        res_level   <= (over && target == '0) ? trim_level(CAP_L) : trim_level(drop_level);
      end
    end else if (state == ST_DIV && div_status.done) begin
      res_level <= trim_level(q_level);
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(excess) * PROD_W'(FS_L);
    end
  end

  ardl_div #(
    .NUM_W (PROD_W),
    .DEN_W (TARGET_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (prod),
    .den      (target),
    .quotient (quotient),
    .status   (div_status)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0, res_level, res_allowed};
    end
  end

`ifndef SYNTHESIS
  a_level_capped : assert property (@(posedge clk) disable iff (rst)
    drop_level <= CAP_L)
    else $error("drop level above the always-drop value");

  a_done_in_div : assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_tick_clears : assert property (@(posedge clk) disable iff (rst)
    accept && is_tick |=> sent == '0)
    else $error("tick did not clear the sent counter");

  a_request_keeps_level : assert property (@(posedge clk) disable iff (rst)
    accept && !is_tick && !is_reply |=> $stable(drop_level) && $stable(sent))
    else $error("own request changed the limiter state");

  a_no_start_while_busy : assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("divider restarted while busy");
`endif

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the adaptive reply drop limiter, with scoreboard and stream drivers.
module tb_top;
  import ardl_pkg::*;

  // What one input beat is: an outgoing-message event or a one-second tick.
  typedef enum bit {
    ACT_MESSAGE = 1'b0,
    ACT_TICK    = 1'b1
  } beat_kind_t;

  // One expected result beat.
  typedef struct packed {
    bit                     allowed;
    logic [LEVEL_OUT_W-1:0] level;
  } limiter_result_t;

  // Drop level meaning "always drop", and the amount a quiet second removes.
  localparam longint unsigned LEVEL_CAP = FULL_SCALE_DEF + 1;
  localparam longint unsigned TICK_STEP = FULL_SCALE_DEF / PERCENT_DIV;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned IDLE_PERCENT  = 33;
  localparam int unsigned PHASE_BEATS   = 105;
  localparam int unsigned SETTLE_CYCLES = 50;
  // The receiver holds off once this many beats have gone in, for this long.
  localparam int unsigned HOLD_AFTER    = 360;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned MAX_PRINTED   = 40;

  // The scoreboard keeps its own copy of the limiter state and the target
  // register, predicts the result of every accepted input beat and compares
  // each accepted result beat with the oldest prediction.
  class drop_limiter_scoreboard;
    logic [TARGET_W-1:0]    target;
    logic [SENT_W-1:0]      sent;
    logic [LEVEL_OUT_W-1:0] level;
    limiter_result_t        awaited[$];
    int unsigned            mismatches;

    function new();
      target     = TARGET_RESET;
      sent       = '0;
      level      = '0;
      mismatches = 0;
    endfunction

    // Drop level for a second that is over target: excess scaled by the
    // target, formed wide and clamped. A zero target always clamps.
    function logic [LEVEL_OUT_W-1:0] overage_level();
      longint unsigned quot;
      if (target == '0)
        return LEVEL_CAP[LEVEL_OUT_W-1:0];
      quot = (64'(sent) - 64'(target)) * FULL_SCALE_DEF / 64'(target);
      if (quot > LEVEL_CAP)
        quot = LEVEL_CAP;
      return quot[LEVEL_OUT_W-1:0];
    endfunction

    function void note_beat(beat_kind_t kind, bit reply, logic [RND_W-1:0] rnd);
      limiter_result_t res;
      res.allowed = 1'b0;
      if (kind == ACT_TICK) begin
        // The reply flag plays no part on a tick.
        if (sent <= target && level != '0)
          level = (level > TICK_STEP) ? level - LEVEL_OUT_W'(TICK_STEP) : '0;
        sent = '0;
      end else if (!reply) begin
        res.allowed = 1'b1;
      end else if (level != '0 && level > rnd) begin
        res.allowed = 1'b0;
      end else begin
        if (sent > target)
          level = overage_level();
        if (sent != SENT_MAX)
          sent = sent + 1'b1;
        res.allowed = 1'b1;
      end
      res.level = level;
      awaited.push_back(res);
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTED)
        $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_beat(bit allowed, logic [LEVEL_OUT_W-1:0] lvl);
      limiter_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result allowed=%0d level=%0d", allowed, lvl));
        return;
      end
      want = awaited.pop_front();
      if (allowed !== want.allowed)
        report($sformatf("send_allowed %0d, expected %0d", allowed, want.allowed));
      if (lvl !== want.level)
        report($sformatf("drop_level_now %0d, expected %0d", lvl, want.level));
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [TARGET_W-1:0] cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [15:0]         s_tdata;   // [14:0] random_value, [15] zero
  logic [1:0]          s_tuser;   // [0] action, [1] is_reply
  logic                m_tvalid;
  logic                m_tready;
  logic [23:0]         m_tdata;   // [0] send_allowed, [16:1] drop_level_now, [23:17] zero

  drop_limiter_scoreboard board;
  int unsigned beats_in    = 0;
  int unsigned cycle_count = 0;
  bit          src_idle    = 1'b1;
  bit          sink_idle   = 1'b1;

  adaptive_reply_drop_limiter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Watchdog: a run that has not finished by now has hung somewhere.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result monitor. Sampling at the rising edge sees the values from before
  // the edge, so the check never depends on the order of processes.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_beat(m_tdata[0], m_tdata[16:1]);
  end

  // Receiver. It stalls at random while idling is enabled, and once during
  // the random part it holds off for a long stretch, counted here, so that
  // the output register stays full and the block has to refuse input beats.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && beats_in >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        m_tready  = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_tready = !(sink_idle && $urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // Offers one beat from the falling edge on, after a random gap, and
  // returns at the rising edge where it is taken. The valid stays high, so
  // the next beat follows without a bubble unless a gap is drawn.
  task send_beat(beat_kind_t kind, bit reply, logic [RND_W-1:0] rnd);
    @(negedge clk);
    while (src_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid              = 1'b1;
    s_tuser[TUSER_ACTION] = kind;
    s_tuser[TUSER_REPLY]  = reply;
    s_tdata               = {1'b0, rnd};
    do @(posedge clk); while (!s_tready);
    board.note_beat(kind, reply, rnd);
    beats_in++;
  endtask

  // Stops offering and waits until every predicted result has come out.
  // Each beat gives exactly one result, so the block is idle after that.
  task drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The target may only change with nothing in flight, hence the drain.
  task write_target(logic [TARGET_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    board.target = value;
  endtask

  // Random values lean towards the extremes now and then, since those
  // decide whether a reply slips under the drop level.
  function logic [RND_W-1:0] pick_random_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return RND_W'($urandom_range(0, 32767));
    endcase
  endfunction

  // One simulated second: a run of messages, mostly replies, closed by a
  // tick. Up to a target of 50 the run length scales with it, so many seconds
  // go over it and the drop level is recomputed and then decays again.
  task send_second(int unsigned target);
    int unsigned run_len;
    if (target > 50)
      run_len = $urandom_range(0, 60);
    else
      run_len = $urandom_range(0, 2 * target + 6);
    repeat (run_len)
      send_beat(ACT_MESSAGE, $urandom_range(0, 3) != 0, pick_random_value());
    send_beat(ACT_TICK, 1'($urandom_range(0, 1)), pick_random_value());
  endtask

  initial begin
    int unsigned phase_target [8];
    int unsigned phase_start;
    board    = new();
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // At the reset target: own requests pass whatever the random value, a
    // tick ignores its reply flag, and replies with no drop level pass.
    send_beat(ACT_MESSAGE, 1'b0, '0);
    send_beat(ACT_MESSAGE, 1'b0, '1);
    send_beat(ACT_TICK,    1'b1, '1);
    send_beat(ACT_TICK,    1'b0, '0);
    send_beat(ACT_MESSAGE, 1'b1, '0);
    send_beat(ACT_MESSAGE, 1'b1, '1);

    // Target of one with two replies already counted: the next replies push
    // the level to full scale and then to the clamp, where everything is
    // dropped; a tick in an overage second leaves the level, a quiet one
    // lowers it.
    write_target(16'd1);
    send_beat(ACT_MESSAGE, 1'b1, '1);
    send_beat(ACT_MESSAGE, 1'b1, '1);
    send_beat(ACT_MESSAGE, 1'b1, '1);
    send_beat(ACT_MESSAGE, 1'b1, '0);
    send_beat(ACT_TICK,    1'b0, '0);
    send_beat(ACT_TICK,    1'b1, 15'd16384);
    send_beat(ACT_MESSAGE, 1'b0, 15'd16384);

    // Zero target: any reply counted this second is an overage, and the
    // division by zero clamps to always drop.
    write_target(16'd0);
    send_beat(ACT_MESSAGE, 1'b1, '1);
    send_beat(ACT_MESSAGE, 1'b1, '1);
    send_beat(ACT_TICK,    1'b0, '1);
    send_beat(ACT_TICK,    1'b0, '1);

    // Random part over several targets, the extremes among them. The fourth
    // phase runs with neither side idling.
    phase_target = '{65535, 1, 0, 5, 17, 0, 40, 100};
    phase_target[5] = $urandom_range(2, 64);
    for (int p = 0; p < 8; p++) begin
      write_target(TARGET_W'(phase_target[p]));
      src_idle    = (p != 3);
      sink_idle   = (p != 3);
      phase_start = beats_in;
      while (beats_in - phase_start < PHASE_BEATS)
        send_second(phase_target[p]);
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;

    // Let any stray result beat show itself before the verdict.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    if (board.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
design/ardl_pkg.sv
design/ardl_div.sv
design/adaptive_reply_drop_limiter.sv
sim/tb_top.sv
